@@ src/pcmf_pkg.sv @@
// shared types and constants of the stereo pcm packet framer
`timescale 1ns / 1ps

package pcmf_pkg;

  localparam int BLOCK_FRAMES_W = 14;
  localparam int PKT_FRAMES_W   = 11;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [PKT_FRAMES_W-1:0] PKT_FRAMES_CAP   = 11'd1024;
  localparam logic [PKT_FRAMES_W-1:0] PKT_FRAMES_RESET = 11'd184;

  localparam logic [31:0] RATE_WORD_RESET   = 32'd48000000;
  localparam logic [31:0] SESSION_TAG_RESET = 32'd0;
  localparam logic [31:0] FRAMER_MAGIC      = 32'h4e4c5354;
  localparam logic [31:0] HEADER_BYTES      = 32'd20;
  localparam logic [15:0] VERSION_LO        = 16'h0201;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PACKET_FRAMES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_WORD         = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SESSION_TAG       = 2'd2;

  typedef struct packed {
    logic [31:0]             left;
    logic [31:0]             right;
    logic                    hdr;
    logic [PKT_FRAMES_W-1:0] frames;
    logic [31:0]             seq;
    logic                    last;
  } job_t;

endpackage

@@ src/pcmf_frame_ctl.sv @@
// input stage: packet and block bookkeeping, job register
`timescale 1ns / 1ps

module pcmf_frame_ctl #(
  parameter int MAX_BLOCK_FRAMES = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_valid,
  output logic                                 frame_stall,
  input  logic [31:0]                          left_sample,
  input  logic [31:0]                          right_sample,
  input  logic [pcmf_pkg::BLOCK_FRAMES_W-1:0]  block_frames,
  input  logic [pcmf_pkg::PKT_FRAMES_W-1:0]    max_packet_frames,
  input  logic                                 job_take,
  output pcmf_pkg::job_t                       job,
  output logic                                 job_valid
);

  localparam int PFW = pcmf_pkg::PKT_FRAMES_W;
  localparam int IBW = pcmf_pkg::BLOCK_FRAMES_W;
  localparam int BW  = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int OW  = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
  localparam int CW  = (BW > IBW) ? BW : IBW;
  localparam int FW  = (BW > PFW) ? BW : PFW;

  logic [OW-1:0]  offset;
  logic [PFW-1:0] remaining;
  logic [31:0]    seq;

  logic           accept;
  logic           start;
  logic [CW-1:0]  bf_wide;
  logic [BW-1:0]  bf;
  logic [PFW-1:0] maxf;
  logic [BW-1:0]  off0;
  logic [BW-1:0]  avail;
  logic [BW-1:0]  off_inc;
  logic [PFW-1:0] frames;
  logic [PFW-1:0] remaining_next;
  logic [OW-1:0]  offset_next;

  assign accept      = frame_valid && !frame_stall;
  assign frame_stall = job_valid && !job_take;
  assign start       = (remaining == '0);

  always_comb begin
    bf_wide = CW'(block_frames);
    if (bf_wide == '0) begin
      bf = BW'(1);
    end else if (bf_wide > CW'(MAX_BLOCK_FRAMES)) begin
      bf = BW'(MAX_BLOCK_FRAMES);
    end else begin
      bf = bf_wide[BW-1:0];
    end

    if (max_packet_frames == '0) begin
      maxf = PFW'(1);
    end else if (max_packet_frames > pcmf_pkg::PKT_FRAMES_CAP) begin
      maxf = pcmf_pkg::PKT_FRAMES_CAP;
    end else begin
      maxf = max_packet_frames;
    end

    off0 = BW'(offset);
    if (start && (off0 >= bf)) begin
      off0 = '0;
    end
    avail = bf - off0;
    if (FW'(avail) > FW'(maxf)) begin
      frames = maxf;
    end else begin
      frames = PFW'(avail);
    end

    remaining_next = start ? (frames - PFW'(1)) : (remaining - PFW'(1));

    off_inc = off0 + BW'(1);
    offset_next = (off_inc >= bf) ? '0 : OW'(off_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      remaining <= '0;
      seq       <= '0;
      job_valid <= 1'b0;
    end else begin
      if (accept) begin
        offset       <= offset_next;
        remaining    <= remaining_next;
        seq          <= start ? (seq + 32'd1) : seq;
        job_valid    <= 1'b1;
        job.left     <= left_sample;
        job.right    <= right_sample;
        job.hdr      <= start;
        job.frames   <= frames;
        job.seq      <= seq;
        job.last     <= (remaining_next == '0);
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  // open packet never owes more than the cap
  a_remaining_cap: assert property (@(posedge clk) disable iff (rst)
    remaining <= pcmf_pkg::PKT_FRAMES_CAP)
    else $error("packet frame count above cap");

  // end flag of the stored job agrees with the packet bookkeeping
  a_job_last: assert property (@(posedge clk) disable iff (rst)
    accept |=> job_valid && (job.last == (remaining == '0)))
    else $error("job end flag disagrees with remaining count");

  // a packet start carries a header with a nonzero frame count
  a_job_hdr: assert property (@(posedge clk) disable iff (rst)
    accept && start |=> job.hdr && (job.frames != '0))
    else $error("packet start without header");

endmodule

@@ src/pcmf_emitter.sv @@
// output stage: walks the words of a job into the output register
`timescale 1ns / 1ps

module pcmf_emitter (
  input  logic           clk,
  input  logic           rst,
  input  pcmf_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_take,
  input  logic [31:0]    rate_word,
  input  logic [31:0]    session_tag,
  output logic           pkt_valid,
  input  logic           pkt_stall,
  output logic [31:0]    word,
  output logic           packet_end
);

  localparam logic [2:0] SLOT_LEN     = 3'd0;
  localparam logic [2:0] SLOT_MAGIC   = 3'd1;
  localparam logic [2:0] SLOT_VERSION = 3'd2;
  localparam logic [2:0] SLOT_SEQ     = 3'd3;
  localparam logic [2:0] SLOT_RATE    = 3'd4;
  localparam logic [2:0] SLOT_TAG     = 3'd5;
  localparam logic [2:0] SLOT_LEFT    = 3'd6;
  localparam logic [2:0] SLOT_RIGHT   = 3'd7;

  logic [2:0]  idx;
  logic [2:0]  slot;
  logic        out_load;
  logic        last_word;
  logic [31:0] word_next;

  assign out_load  = !pkt_valid || !pkt_stall;
  assign slot      = job.hdr ? idx : (idx + SLOT_LEFT);
  assign last_word = (slot == SLOT_RIGHT);
  assign job_take  = job_valid && out_load && last_word;

  always_comb begin
    case (slot)
      SLOT_LEN:     word_next = pcmf_pkg::HEADER_BYTES + 32'({job.frames, 3'b000});
      SLOT_MAGIC:   word_next = pcmf_pkg::FRAMER_MAGIC;
      SLOT_VERSION: word_next = {5'b0, job.frames, pcmf_pkg::VERSION_LO};
      SLOT_SEQ:     word_next = job.seq;
      SLOT_RATE:    word_next = rate_word;
      SLOT_TAG:     word_next = session_tag;
      SLOT_LEFT:    word_next = job.left;
      SLOT_RIGHT:   word_next = job.right;
      default:      word_next = job.right;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      idx       <= '0;
    end else if (out_load) begin
      pkt_valid <= job_valid;
      if (job_valid) begin
        word       <= word_next;
        packet_end <= last_word && job.last;
        idx        <= last_word ? 3'd0 : (idx + 3'd1);
      end
    end
  end

  // finishing a job puts its right word, with the job's end flag, on the output
  a_take_out: assert property (@(posedge clk) disable iff (rst)
    job_take |=> pkt_valid && (packet_end == $past(job.last)))
    else $error("job finished without its last word on the output");

  // a job without header only walks the two sample words
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.hdr |-> idx <= 3'd1)
    else $error("word index out of range for sample only job");

  // a stalled output item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(word) && $stable(packet_end))
    else $error("output item changed while stalled");

endmodule

@@ src/pcm_audio_packet_framer.sv @@
// top level of the stereo pcm packet framer: config registers and stages
//
//   channel   signals                                         handshake
//   frame     left_sample right_sample block_frames           frame_valid / frame_stall
//   pkt       word packet_end                                 pkt_valid / pkt_stall
//   cfg       cfg_index cfg_data                              cfg_valid / cfg_ready
//
// one output word per cycle while pkt_stall is low: two words per frame, eight for a frame that opens a packet
// first word of an item goes out through the job register and then the output register
// next frame is taken in the cycle the last word of the current one enters the output register
// synchronous reset clears packet state and loads the register defaults
`timescale 1ns / 1ps

module pcm_audio_packet_framer #(
  parameter int MAX_BLOCK_FRAMES = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_valid,
  output logic                                frame_stall,
  input  logic [31:0]                         left_sample,
  input  logic [31:0]                         right_sample,
  input  logic [pcmf_pkg::BLOCK_FRAMES_W-1:0] block_frames,
  output logic                                pkt_valid,
  input  logic                                pkt_stall,
  output logic [31:0]                         word,
  output logic                                packet_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic [pcmf_pkg::PKT_FRAMES_W-1:0] max_packet_frames;
  logic [31:0]                       rate_word;
  logic [31:0]                       session_tag;

  pcmf_pkg::job_t job;
  logic           job_valid;
  logic           job_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_frames <= pcmf_pkg::PKT_FRAMES_RESET;
      rate_word         <= pcmf_pkg::RATE_WORD_RESET;
      session_tag       <= pcmf_pkg::SESSION_TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcmf_pkg::CFG_MAX_PACKET_FRAMES: begin
          max_packet_frames <= cfg_data[pcmf_pkg::PKT_FRAMES_W-1:0];
        end
        pcmf_pkg::CFG_RATE_WORD: begin
          rate_word <= cfg_data;
        end
        pcmf_pkg::CFG_SESSION_TAG: begin
          session_tag <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  pcmf_frame_ctl #(
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
  ) u_frame_ctl (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame_stall       (frame_stall),
    .left_sample       (left_sample),
    .right_sample      (right_sample),
    .block_frames      (block_frames),
    .max_packet_frames (max_packet_frames),
    .job_take          (job_take),
    .job               (job),
    .job_valid         (job_valid)
  );

  pcmf_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_valid   (job_valid),
    .job_take    (job_take),
    .rate_word   (rate_word),
    .session_tag (session_tag),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .word        (word),
    .packet_end  (packet_end)
  );

endmodule
